### src/sirt_pkg.sv
// Shared types and constants for the signed integer to radix text converter.
// Used by sirt_ctrl, sirt_dp and the top level; depends on nothing else.
package sirt_pkg;

    // Fixed widths of the stream payloads and configuration registers.
    localparam int IN_DATA_W  = 32;
    localparam int CHAR_W     = 8;
    localparam int BASE_W     = 5;
    localparam int SYM_BANK_W = 64;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_SYMS   = 16;
    localparam int SYM_IDX_W  = 4;

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
    localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    localparam logic [BASE_W-1:0]     BASE_LENGTH_RST  = 5'd2;
    localparam logic [SYM_BANK_W-1:0] SYMBOLS_LOW_RST  = 64'h3130;
    localparam logic [SYM_BANK_W-1:0] SYMBOLS_HIGH_RST = 64'h0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic div_step;
        logic push;
        logic emit_sign;
        logic emit_digit;
    } sirt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sym_ok;
        logic neg;
        logic div_last;
        logic q_zero;
        logic out_free;
        logic sp_one;
    } sirt_status_t;

endpackage

### src/sirt_ctrl.sv
// Controller state machine of the radix text converter.
// Depends on sirt_pkg; drives sirt_dp through command and status structs.
module sirt_ctrl
    import sirt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  sirt_status_t status,
    output sirt_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_PUSH,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // An invalid symbol set swallows the word without any output.
                state_next = status.sym_ok ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                cmd.push = 1'b1;
                if (status.q_zero) begin
                    state_next = status.neg ? ST_SIGN : ST_DIGITS;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_SIGN: begin
                if (status.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (status.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (status.sp_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    ast_one_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.emit_sign && cmd.emit_digit))
        else $error("sign and digit emitted together");
    ast_check_after_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == ST_CHECK))
        else $error("capture not followed by symbol check");
    ast_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> !s_tready)
        else $error("input ready while dividing");

endmodule

### src/sirt_dp.sv
// Datapath of the radix text converter: configuration registers, symbol check,
// bit-serial restoring divider, digit stack and output register. Depends on sirt_pkg.
module sirt_dp
    import sirt_pkg::*;
#(
    parameter int MAX_RADIX    = 16,
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [CHAR_W-1:0]     m_tdata,
    output logic                  m_tlast,
    input  sirt_cmd_t             cmd,
    output sirt_status_t          status
);

    localparam int DIGIT_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
    localparam int CNT_W   = $clog2(NUMBER_WIDTH);
    localparam int SP_W    = $clog2(NUMBER_WIDTH + 1);
    localparam int IDX_W   = $clog2(NUMBER_WIDTH);

    function automatic logic symbols_ok(input logic [BASE_W-1:0] len,
                                        input logic [NUM_SYMS*CHAR_W-1:0] syms);
        logic ok;
        logic [CHAR_W-1:0] si;
        ok = 1'b1;
        for (int i = 0; i < NUM_SYMS; i++) begin
            si = syms[CHAR_W*i +: CHAR_W];
            if (BASE_W'(i) < len) begin
                if (si == '0 || si == PLUS_CHAR || si == MINUS_CHAR) begin
                    ok = 1'b0;
                end
                for (int j = i + 1; j < NUM_SYMS; j++) begin
                    if (BASE_W'(j) < len && syms[CHAR_W*j +: CHAR_W] == si) begin
                        ok = 1'b0;
                    end
                end
            end
        end
        return ok;
    endfunction

    logic [BASE_W-1:0]     base_length_reg;
    logic [SYM_BANK_W-1:0] symbols_low_reg;
    logic [SYM_BANK_W-1:0] symbols_high_reg;
    logic [NUM_SYMS*CHAR_W-1:0] syms;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_length_reg  <= BASE_LENGTH_RST;
            symbols_low_reg  <= SYMBOLS_LOW_RST;
            symbols_high_reg <= SYMBOLS_HIGH_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_BASE_LENGTH) begin
                base_length_reg <= cfg_wr_data[BASE_W-1:0];
            end
            if (cfg_index == REG_SYMBOLS_LOW) begin
                symbols_low_reg <= cfg_wr_data;
            end
            if (cfg_index == REG_SYMBOLS_HIGH) begin
                symbols_high_reg <= cfg_wr_data;
            end
        end
    end

    assign syms = {symbols_high_reg, symbols_low_reg};

    // Operand capture and restoring divider. The quotient register starts out
    // holding the magnitude and is shifted one quotient bit in per cycle.
    logic [NUMBER_WIDTH-1:0] raw;
    logic [NUMBER_WIDTH-1:0] mag;
    logic [NUMBER_WIDTH-1:0] q_reg;
    logic [BASE_W-1:0]       rem_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    neg_reg;
    logic [BASE_W:0]         trial;
    logic                    ge;
    logic [BASE_W:0]         diff;

    assign raw   = s_tdata[NUMBER_WIDTH-1:0];
    assign mag   = raw[NUMBER_WIDTH-1] ? (~raw + NUMBER_WIDTH'(1)) : raw;
    assign trial = {rem_reg, q_reg[NUMBER_WIDTH-1]};
    assign ge    = (trial >= {1'b0, base_length_reg});
    assign diff  = trial - {1'b0, base_length_reg};

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            q_reg   <= mag;
            neg_reg <= raw[NUMBER_WIDTH-1];
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            q_reg   <= {q_reg[NUMBER_WIDTH-2:0], ge};
            rem_reg <= ge ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
            cnt_reg <= cnt_reg + CNT_W'(1);
        end else if (cmd.push) begin
            rem_reg <= '0;
            cnt_reg <= '0;
        end
    end

    // Digit stack, least significant digit pushed first.
    logic [DIGIT_W-1:0] stack_reg [NUMBER_WIDTH];
    logic [SP_W-1:0]    sp_reg;
    logic [SP_W-1:0]    sp_dec;
    logic [DIGIT_W-1:0] top_digit;
    logic [CHAR_W-1:0]  top_char;

    assign sp_dec    = sp_reg - SP_W'(1);
    assign top_digit = stack_reg[sp_dec[IDX_W-1:0]];
    assign top_char  = syms[CHAR_W*SYM_IDX_W'(top_digit) +: CHAR_W];

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            stack_reg[sp_reg[IDX_W-1:0]] <= rem_reg[DIGIT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
        end else if (cmd.push) begin
            sp_reg <= sp_reg + SP_W'(1);
        end else if (cmd.emit_digit) begin
            sp_reg <= sp_dec;
        end
    end

    // Output register.
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_last_reg;
    logic              out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_sign || cmd.emit_digit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_sign) begin
            out_char_reg <= MINUS_CHAR;
            out_last_reg <= 1'b0;
        end else if (cmd.emit_digit) begin
            out_char_reg <= top_char;
            out_last_reg <= (sp_reg == SP_W'(1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    assign status.sym_ok   = (base_length_reg >= BASE_W'(2))
                           && (base_length_reg <= BASE_W'(MAX_RADIX))
                           && symbols_ok(base_length_reg, syms);
    assign status.neg      = neg_reg;
    assign status.div_last = (cnt_reg == CNT_W'(NUMBER_WIDTH - 1));
    assign status.q_zero   = (q_reg == '0);
    assign status.out_free = out_free;
    assign status.sp_one   = (sp_reg == SP_W'(1));

    ast_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (sp_reg < SP_W'(NUMBER_WIDTH)))
        else $error("digit stack overflow");
    ast_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_digit |-> (sp_reg != '0))
        else $error("digit stack underflow");
    ast_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_sign || cmd.emit_digit) |-> (!out_valid_reg || m_tready))
        else $error("output word overwritten before it was taken");

endmodule

### src/signed_integer_to_radix_text.sv
// After a word is taken, ST_CHECK runs the symbol check; each digit then comes from the
// bit-serial divider, one quotient bit per cycle, and is pushed onto the digit stack.
// Characters then leave at one per cycle while the output register is free (m_tready).
// A new word is taken only after the last character of the previous word is emitted.
// Reset (aresetn low, synchronous) empties the pipeline and restores radix 2 with "01".
module signed_integer_to_radix_text
    import sirt_pkg::*;
#(
    parameter int MAX_RADIX    = 16,
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port: 0 base_length, 1 symbols_low, 2 symbols_high.
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] number (signed)
    // Character stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [CHAR_W-1:0]     m_tdata,   // [7:0] out_char
    output logic                  m_tlast    // last
);

    // The controller sequences capture, the symbol check, the digit loop and the
    // emission of characters; the datapath holds all storage and arithmetic.
    sirt_cmd_t    cmd;
    sirt_status_t status;

    sirt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath divides the magnitude repeatedly by the radix, stacking each
    // remainder, and then pops the digits so that the most significant leaves first.
    // Its output register lets the next word be taken while the final character waits.
    sirt_dp #(
        .MAX_RADIX    (MAX_RADIX),
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
